### hw/rtl/ijs_pkg.sv
// Shared types, widths and helpers for the impedance joint simulator.
// No dependencies; imported by the interfaces, the multiplier, the top level and the checker.
package ijs_pkg;

    // Table size and number format
    localparam int JOINT_COUNT   = 8;
    localparam int FRACTION_BITS = 16;

    // Field widths
    localparam int JOINT_W  = 3;
    localparam int DATA_W   = 32;
    localparam int DT_W     = 17;
    localparam int LIMIT_W  = 31;
    localparam int STATUS_W = 2;

    // Table address width
    localparam int JOINT_AW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

    // Shared multiplier: one spare bit so the unsigned time step fits as a signed operand
    localparam int MUL_W  = DATA_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int TERM_W = PROD_W - FRACTION_BITS;
    localparam int SUM_W  = TERM_W + 2;

    // One second in time-step units
    localparam logic [31:0] ONE_SECOND = 32'(1) << FRACTION_BITS;

    // Command codes
    localparam logic CMD_INIT = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_STEPPED = 2'd0,
        ST_SKIPPED = 2'd1,
        ST_INIT    = 2'd2
    } status_t;

    // One row of the joint table
    typedef struct packed {
        logic signed [DATA_W-1:0]  pos;
        logic signed [DATA_W-1:0]  vel;
        logic signed [DATA_W-1:0]  eff;
        logic        [LIMIT_W-1:0] lim;
        logic signed [DATA_W-1:0]  damp;
    } joint_entry_t;

    // Saturate a wide signed value to the 32-bit signed range
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        lo = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
        if (v > hi)
            return hi[DATA_W-1:0];
        else if (v < lo)
            return lo[DATA_W-1:0];
        else
            return v[DATA_W-1:0];
    endfunction

endpackage

### hw/rtl/ijs_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on ijs_pkg for field widths.
interface ijs_request_if import ijs_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic        [JOINT_W-1:0] joint;
    logic signed [DATA_W-1:0]  target_position;
    logic signed [DATA_W-1:0]  target_velocity;
    logic signed [DATA_W-1:0]  feedforward_effort;
    logic signed [DATA_W-1:0]  stiffness_gain;
    logic signed [DATA_W-1:0]  damping_gain;
    logic        [DT_W-1:0]    time_step;
    logic signed [DATA_W-1:0]  start_position;
    logic        [LIMIT_W-1:0] effort_limit;
    logic signed [DATA_W-1:0]  passive_damping;

    modport source (
        output valid, command, joint, target_position, target_velocity,
               feedforward_effort, stiffness_gain, damping_gain, time_step,
               start_position, effort_limit, passive_damping,
        input  ready
    );
    modport sink (
        input  valid, command, joint, target_position, target_velocity,
               feedforward_effort, stiffness_gain, damping_gain, time_step,
               start_position, effort_limit, passive_damping,
        output ready
    );
endinterface

interface ijs_result_if import ijs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic        [JOINT_W-1:0]  joint_out;
    logic        [STATUS_W-1:0] status;
    logic signed [DATA_W-1:0]   position_out;
    logic signed [DATA_W-1:0]   velocity_out;
    logic signed [DATA_W-1:0]   effort_out;

    modport source (
        output valid, joint_out, status, position_out, velocity_out, effort_out,
        input  ready
    );
    modport sink (
        input  valid, joint_out, status, position_out, velocity_out, effort_out,
        output ready
    );
endinterface

### hw/rtl/ijs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ijs_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/ijs_mul.sv
// Shared signed multiplier with a registered product.
// Depends on ijs_pkg for operand and product widths.
module ijs_mul import ijs_pkg::*; (
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod
);

    // Full-precision product, registered
    always_ff @(posedge clk)
    begin
        prod <= a * b;
    end

endmodule

### hw/rtl/impedance_joint_simulator.sv
// Impedance joint simulator: PD effort law and semi-implicit Euler update per joint.
// Step item: table row read, then five passes through the single shared multiplier, then
// table write-back as the result is handed over to a free output register; a new item
// is taken only after that hand-over. Init, skipped-step and out-of-range items go from the row read straight to it.
// Reset (async, active low) clears the per-joint valid bits so every joint reads zero.
// Depends on ijs_pkg, ijs_if, ijs_ram and ijs_mul.
module impedance_joint_simulator import ijs_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    ijs_request_if.sink    request,
    ijs_result_if.source   result
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_KP, S_KD, S_DAMP, S_SUM, S_EDT, S_VEL, S_VDT, S_POS, S_DONE
    } state_t;

    state_t state_reg;

    // Latched request fields
    logic                      cmd_reg;
    logic        [JOINT_W-1:0] joint_reg;
    logic signed [DATA_W-1:0]  tp_reg, tv_reg, ff_reg, kp_reg, kd_reg;
    logic        [DT_W-1:0]    dt_reg;
    logic signed [DATA_W-1:0]  sp_reg, pd_reg;
    logic        [LIMIT_W-1:0] el_reg;

    // Working copy of the joint row
    logic signed [DATA_W-1:0]  pos_reg, vel_reg, eff_reg, damp_reg;
    logic        [LIMIT_W-1:0] lim_reg;
    logic signed [DATA_W-1:0]  dpos_reg, dvel_reg;
    logic signed [SUM_W-1:0]   acc_reg;
    status_t                   status_reg;
    logic                      wr_reg;

    // Output register
    logic                      out_valid_reg;
    logic        [JOINT_W-1:0] out_joint_reg;
    status_t                   out_status_reg;
    logic signed [DATA_W-1:0]  out_pos_reg, out_vel_reg, out_eff_reg;

    // Per-joint valid bits: an unwritten row reads as zero
    logic [JOINT_COUNT-1:0]    valid_reg;

    logic                      ram_we;
    logic [JOINT_AW-1:0]       waddr;
    joint_entry_t              ram_wdata, ram_rdata, entry;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [TERM_W-1:0]  term;
    logic signed [SUM_W-1:0]   sum_v, lim_s;
    logic signed [DATA_W-1:0]  eff_clamped;
    logic                      in_range, dt_bad, can_out;

    ijs_ram #(.WIDTH($bits(joint_entry_t)), .DEPTH(JOINT_COUNT)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (ram_wdata),
        .raddr (JOINT_AW'(request.joint)),
        .rdata (ram_rdata)
    );

    ijs_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Address decode, validity and time-step check
    assign waddr    = JOINT_AW'(joint_reg);
    assign in_range = 32'(joint_reg) < JOINT_COUNT;
    assign dt_bad   = (dt_reg == '0) || (32'(dt_reg) > ONE_SECOND);
    assign entry    = valid_reg[waddr] ? ram_rdata : '0;
    assign can_out  = !out_valid_reg || result.ready;

    // Floor of product / 2^FRACTION_BITS
    assign term = prod[PROD_W-1:FRACTION_BITS];

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_KP:
            begin
                mul_a = MUL_W'(kp_reg);
                mul_b = MUL_W'(dpos_reg);
            end
            S_KD:
            begin
                mul_a = MUL_W'(kd_reg);
                mul_b = MUL_W'(dvel_reg);
            end
            S_DAMP:
            begin
                mul_a = MUL_W'(damp_reg);
                mul_b = MUL_W'(vel_reg);
            end
            S_EDT:
            begin
                mul_a = MUL_W'(eff_reg);
                mul_b = MUL_W'(dt_reg);
            end
            S_VDT:
            begin
                mul_a = MUL_W'(vel_reg);
                mul_b = MUL_W'(dt_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Final sum minus passive damping, clamped to the joint limit
    always_comb
    begin
        sum_v = acc_reg - SUM_W'(term);
        lim_s = SUM_W'(lim_reg);
        if (sum_v > lim_s)
            eff_clamped = lim_s[DATA_W-1:0];
        else if (sum_v < -lim_s)
            eff_clamped = DATA_W'(-lim_s);
        else
            eff_clamped = sum_v[DATA_W-1:0];
    end

    // Table write-back
    assign ram_we    = (state_reg == S_DONE) && can_out && wr_reg;
    assign ram_wdata = '{pos: pos_reg, vel: vel_reg, eff: eff_reg, lim: lim_reg, damp: damp_reg};

    // Sequencer, datapath registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_joint_reg  <= '0;
            out_status_reg <= ST_STEPPED;
            out_pos_reg    <= '0;
            out_vel_reg    <= '0;
            out_eff_reg    <= '0;
            cmd_reg        <= CMD_INIT;
            joint_reg      <= '0;
            tp_reg         <= '0;
            tv_reg         <= '0;
            ff_reg         <= '0;
            kp_reg         <= '0;
            kd_reg         <= '0;
            dt_reg         <= '0;
            sp_reg         <= '0;
            pd_reg         <= '0;
            el_reg         <= '0;
            pos_reg        <= '0;
            vel_reg        <= '0;
            eff_reg        <= '0;
            damp_reg       <= '0;
            lim_reg        <= '0;
            dpos_reg       <= '0;
            dvel_reg       <= '0;
            acc_reg        <= '0;
            status_reg     <= ST_STEPPED;
            wr_reg         <= 1'b0;
        end
        else
        begin
            // Result register: set on hand-over, cleared once taken
            if ((state_reg == S_DONE) && can_out)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (request.valid)
                    begin
                        cmd_reg   <= request.command;
                        joint_reg <= request.joint;
                        tp_reg    <= request.target_position;
                        tv_reg    <= request.target_velocity;
                        ff_reg    <= request.feedforward_effort;
                        kp_reg    <= request.stiffness_gain;
                        kd_reg    <= request.damping_gain;
                        dt_reg    <= request.time_step;
                        sp_reg    <= request.start_position;
                        el_reg    <= request.effort_limit;
                        pd_reg    <= request.passive_damping;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    // Row read is back; pick the path
                    dpos_reg <= sat_data(SUM_W'(tp_reg) - SUM_W'(entry.pos));
                    dvel_reg <= sat_data(SUM_W'(tv_reg) - SUM_W'(entry.vel));
                    if (!in_range)
                    begin
                        pos_reg    <= '0;
                        vel_reg    <= '0;
                        eff_reg    <= '0;
                        lim_reg    <= entry.lim;
                        damp_reg   <= entry.damp;
                        status_reg <= (cmd_reg == CMD_STEP) ? ST_SKIPPED : ST_INIT;
                        wr_reg     <= 1'b0;
                        state_reg  <= S_DONE;
                    end
                    else if (cmd_reg == CMD_INIT)
                    begin
                        pos_reg    <= sp_reg;
                        vel_reg    <= '0;
                        eff_reg    <= '0;
                        lim_reg    <= el_reg;
                        damp_reg   <= pd_reg;
                        status_reg <= ST_INIT;
                        wr_reg     <= 1'b1;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        pos_reg  <= entry.pos;
                        vel_reg  <= entry.vel;
                        eff_reg  <= entry.eff;
                        lim_reg  <= entry.lim;
                        damp_reg <= entry.damp;
                        if (dt_bad)
                        begin
                            status_reg <= ST_SKIPPED;
                            wr_reg     <= 1'b0;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            status_reg <= ST_STEPPED;
                            wr_reg     <= 1'b1;
                            state_reg  <= S_KP;
                        end
                    end
                end
                S_KP:
                begin
                    state_reg <= S_KD;
                end
                S_KD:
                begin
                    // Stiffness term is ready
                    acc_reg   <= SUM_W'(ff_reg) + SUM_W'(term);
                    state_reg <= S_DAMP;
                end
                S_DAMP:
                begin
                    // Damping-gain term is ready
                    acc_reg   <= acc_reg + SUM_W'(term);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    eff_reg   <= eff_clamped;
                    state_reg <= S_EDT;
                end
                S_EDT:
                begin
                    state_reg <= S_VEL;
                end
                S_VEL:
                begin
                    vel_reg   <= sat_data(SUM_W'(vel_reg) + SUM_W'(term));
                    state_reg <= S_VDT;
                end
                S_VDT:
                begin
                    state_reg <= S_POS;
                end
                S_POS:
                begin
                    pos_reg   <= sat_data(SUM_W'(pos_reg) + SUM_W'(term));
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // Hand the result over once the output register is free
                    if (can_out)
                    begin
                        out_joint_reg  <= joint_reg;
                        out_status_reg <= status_reg;
                        out_pos_reg    <= pos_reg;
                        out_vel_reg    <= vel_reg;
                        out_eff_reg    <= eff_reg;
                        if (wr_reg)
                            valid_reg[waddr] <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign request.ready       = (state_reg == S_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.joint_out    = out_joint_reg;
    assign result.status       = out_status_reg;
    assign result.position_out = out_pos_reg;
    assign result.velocity_out = out_vel_reg;
    assign result.effort_out   = out_eff_reg;

endmodule

### hw/rtl/ijs_checker.sv
// Port-level checker for the impedance joint simulator, bound to the top level.
// Depends on ijs_pkg and on the top level's interface ports.
module ijs_checker import ijs_pkg::*; (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic        [STATUS_W-1:0] status,
    input logic signed [DATA_W-1:0]   velocity_out,
    input logic signed [DATA_W-1:0]   effort_out
);

    // A held result stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // One item at a time: no second accept right after one
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while an item is in flight");

    // No result can appear the cycle after acceptance
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

    // Init results carry zero velocity and effort
    a_init_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_INIT) |-> (velocity_out == '0) && (effort_out == '0))
        else $error("init result with nonzero velocity or effort");

endmodule

bind impedance_joint_simulator ijs_checker u_ijs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (request.valid),
    .in_ready     (request.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .status       (result.status),
    .velocity_out (result.velocity_out),
    .effort_out   (result.effort_out)
);
